/* hw/rtl/linear_gradient_shader_defines.svh */
// Assertion macros used by the linear gradient shader checker.
`ifndef LINEAR_GRADIENT_SHADER_DEFINES_SVH
`define LINEAR_GRADIENT_SHADER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lgs_pkg.sv */
// Types, constants and a helper function of the linear gradient shader.
package lgs_pkg;

  localparam int LGS_MAX_STOPS = 16;

  // Product of a Q7.32 coefficient and a 12-bit coordinate, and the sum of three terms.
  localparam int LGS_PROD_W = 53;
  localparam int LGS_SUM_W  = 55;

  localparam logic [32:0] LGS_ONE_Q32 = 33'h1_0000_0000;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int LGS_APB_AW = 6;
  localparam int LGS_APB_DW = 64;

  localparam logic [2:0] LGS_REG_COEFF_X      = 3'd0;
  localparam logic [2:0] LGS_REG_COEFF_Y      = 3'd1;
  localparam logic [2:0] LGS_REG_COEFF_OFFSET = 3'd2;
  localparam logic [2:0] LGS_REG_TILE_MODE    = 3'd3;
  localparam logic [2:0] LGS_REG_STOP_COUNT   = 3'd4;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_e;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [39:0] coeff_x;
    logic signed [39:0] coeff_y;
    logic signed [39:0] coeff_offset;
    tile_e              tile_mode;
    logic [4:0]         stop_count;
  } cfg_t;

  // One colour stop, each channel unsigned Q1.12 in [0, 4096].
  typedef struct packed {
    logic [12:0] r;
    logic [12:0] g;
    logic [12:0] b;
    logic [12:0] a;
  } stop_t;

  // Shade transaction leaving the parameter pipeline towards the colour pipeline.
  typedef struct packed {
    logic        valid;
    logic        span_end;
    logic [31:0] frac;
  } seg_t;

  function automatic int lgs_idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* hw/rtl/lgs_param_pipe.sv */
// Stages 1 to 4: gradient parameter, tiling and stop segment selection.
module lgs_param_pipe import lgs_pkg::*; #(
  parameter int MAX_STOPS = LGS_MAX_STOPS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic [0:0]                            command_i,
  input  logic [11:0]                           pixel_x_i,
  input  logic [11:0]                           pixel_y_i,
  input  logic                                  row_end_i,
  input  logic [3:0]                            stop_index_i,
  input  logic signed [15:0]                    red_in_i,
  input  logic signed [15:0]                    green_in_i,
  input  logic signed [15:0]                    blue_in_i,
  input  logic signed [15:0]                    alpha_in_i,
  input  logic                                  dn_en_i,
  output seg_t                                  seg_o,
  output logic [lgs_idx_w(MAX_STOPS)-1:0]       rd_lo_o,
  output logic [lgs_idx_w(MAX_STOPS)-1:0]       rd_hi_o,
  output logic                                  wr_en_o,
  output logic [lgs_idx_w(MAX_STOPS)-1:0]       wr_idx_o,
  output stop_t                                 wr_stop_o
);

  localparam int IdxW = lgs_idx_w(MAX_STOPS);
  localparam int CntW = $clog2(MAX_STOPS + 1);
  localparam int PW   = 32 + IdxW;
  localparam logic signed [LGS_SUM_W-1:0] TOne = LGS_SUM_W'(LGS_ONE_Q32);

  function automatic logic [12:0] pin(input logic signed [15:0] s);
    logic [12:0] r;
    if (s < 16'sd0) begin
      r = 13'd0;
    end else if (s > 16'sd4096) begin
      r = 13'd4096;
    end else begin
      r = s[12:0];
    end
    return r;
  endfunction

  logic [4:1] v_q;
  logic [4:1] en;

  logic [4:1] shade_q;
  logic [4:1] span_q;
  logic [4:1] ok_q;
  logic [IdxW-1:0] widx_q [4:1];
  stop_t           wstop_q [4:1];

  logic signed [LGS_PROD_W-1:0] mx1_q, my1_q, mx_d, my_d;
  logic signed [LGS_SUM_W-1:0]  ts2_q, ts_d;
  logic [31:0]     t3_q;
  logic            end3_q;
  logic [IdxW-1:0] eidx3_q, n3_q;
  logic [IdxW-1:0] lo4_q, hi4_q;
  logic [31:0]     f4_q;

  logic [32:0]     t, m;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] n;
  logic            is_zero, is_full;
  logic [PW-1:0]   prod;
  logic [IdxW-1:0] idx, lo_d, hi_d;
  logic [31:0]     f_d;
  logic [IdxW-1:0] widx_d;
  stop_t           wstop_d;
  logic            ok_d;

  // A stage takes a new transaction when it is empty or its content moves on.
  assign en[4]   = !v_q[4] || dn_en_i;
  assign en[3]   = !v_q[3] || en[4];
  assign en[2]   = !v_q[2] || en[3];
  assign en[1]   = !v_q[1] || en[2];
  assign stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  // Stage 1: coordinate products and stop pinning.
  always_comb begin
    mx_d = cfg_i.coeff_x * $signed({1'b0, pixel_x_i});
    my_d = cfg_i.coeff_y * $signed({1'b0, pixel_y_i});
    wstop_d.r = pin(red_in_i);
    wstop_d.g = pin(green_in_i);
    wstop_d.b = pin(blue_in_i);
    wstop_d.a = pin(alpha_in_i);
    widx_d = IdxW'({{IdxW{1'b0}}, stop_index_i});
    ok_d   = 32'(stop_index_i) < MAX_STOPS;
  end

  // Stage 3: tiling, clamping and end stop detection.
  always_comb begin
    if (cfg_i.stop_count == 5'd0) begin
      cnt = CntW'(1);
    end else if (32'(cfg_i.stop_count) > MAX_STOPS) begin
      cnt = CntW'(MAX_STOPS);
    end else begin
      cnt = CntW'(cfg_i.stop_count);
    end
    n = IdxW'(cnt - CntW'(1));
    m = ts2_q[32:0];
    unique case (cfg_i.tile_mode)
      TILE_REPEAT: begin
        t = {1'b0, ts2_q[31:0]};
      end
      TILE_MIRROR: begin
        if (m > LGS_ONE_Q32) begin
          t = 33'(34'h2_0000_0000 - {1'b0, m});
        end else begin
          t = m;
        end
      end
      default: begin
        if (ts2_q[LGS_SUM_W-1]) begin
          t = '0;
        end else if (ts2_q > TOne) begin
          t = LGS_ONE_Q32;
        end else begin
          t = ts2_q[32:0];
        end
      end
    endcase
    is_zero = (t == '0) || (n == '0);
    is_full = t[32];
  end

  // Stage 4: segment index and local fraction. End stops blend with a zero fraction.
  always_comb begin
    prod = PW'(t3_q) * PW'(n3_q);
    idx  = prod[PW-1:32];
    if (idx >= n3_q) begin
      idx = n3_q - IdxW'(1);
    end
    if (end3_q) begin
      lo_d = eidx3_q;
      hi_d = eidx3_q;
      f_d  = '0;
    end else begin
      lo_d = idx;
      hi_d = idx + IdxW'(1);
      f_d  = prod[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      shade_q[1] <= (command_i == CMD_SHADE);
      span_q[1]  <= row_end_i;
      ok_q[1]    <= ok_d;
      widx_q[1]  <= widx_d;
      wstop_q[1] <= wstop_d;
      mx1_q      <= mx_d;
      my1_q      <= my_d;
    end
    if (en[2]) begin
      shade_q[2] <= shade_q[1];
      span_q[2]  <= span_q[1];
      ok_q[2]    <= ok_q[1];
      widx_q[2]  <= widx_q[1];
      wstop_q[2] <= wstop_q[1];
      ts2_q      <= LGS_SUM_W'(mx1_q) + LGS_SUM_W'(my1_q) + LGS_SUM_W'(cfg_i.coeff_offset);
    end
    if (en[3]) begin
      shade_q[3] <= shade_q[2];
      span_q[3]  <= span_q[2];
      ok_q[3]    <= ok_q[2];
      widx_q[3]  <= widx_q[2];
      wstop_q[3] <= wstop_q[2];
      t3_q       <= t[31:0];
      end3_q     <= is_zero || is_full;
      eidx3_q    <= is_zero ? '0 : n;
      n3_q       <= n;
    end
    if (en[4]) begin
      shade_q[4] <= shade_q[3];
      span_q[4]  <= span_q[3];
      ok_q[4]    <= ok_q[3];
      widx_q[4]  <= widx_q[3];
      wstop_q[4] <= wstop_q[3];
      lo4_q      <= lo_d;
      hi4_q      <= hi_d;
      f4_q       <= f_d;
    end
  end

  // A load writes the stop table as it leaves stage 4, in order with the reads.
  assign wr_en_o        = v_q[4] && !shade_q[4] && ok_q[4] && dn_en_i;
  assign wr_idx_o       = widx_q[4];
  assign wr_stop_o      = wstop_q[4];
  assign rd_lo_o        = lo4_q;
  assign rd_hi_o        = hi4_q;
  assign seg_o.valid    = v_q[4] && shade_q[4];
  assign seg_o.span_end = span_q[4];
  assign seg_o.frac     = f4_q;

endmodule

/* hw/rtl/lgs_stop_ram.sv */
// Colour stop table: one write port and two registered read ports.
module lgs_stop_ram import lgs_pkg::*; #(
  parameter int MAX_STOPS = LGS_MAX_STOPS
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [lgs_idx_w(MAX_STOPS)-1:0] wr_idx_i,
  input  stop_t                           wr_data_i,
  input  logic                            rd_en_i,
  input  logic [lgs_idx_w(MAX_STOPS)-1:0] rd_lo_idx_i,
  input  logic [lgs_idx_w(MAX_STOPS)-1:0] rd_hi_idx_i,
  output stop_t                           rd_lo_o,
  output stop_t                           rd_hi_o
);

  stop_t mem [MAX_STOPS];
  stop_t rd_lo_q, rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_lo_q <= mem[rd_lo_idx_i];
      rd_hi_q <= mem[rd_hi_idx_i];
    end
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

/* hw/rtl/lgs_color_pipe.sv */
// Stages 5 to 8: stop blending, premultiplication and pixel packing.
module lgs_color_pipe import lgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seg_t        seg_i,
  output logic        en_o,
  input  stop_t       stop_lo_i,
  input  stop_t       stop_hi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_out_o,
  output logic        span_end_o
);

  function automatic logic [12:0] blend(input logic [12:0] c1, input logic [12:0] c2,
                                        input logic [31:0] f);
    logic signed [13:0] d;
    logic signed [47:0] acc;
    d   = $signed({1'b0, c2}) - $signed({1'b0, c1});
    acc = $signed({3'b000, c1, 32'd0}) + 48'(d * $signed({1'b0, f}))
          + 48'sd2147483648;
    return acc[44:32];
  endfunction

  function automatic logic [7:0] scale_c(input logic [25:0] ca);
    logic [33:0] x;
    x = ({8'd0, ca} << 8) - {8'd0, ca} + 34'd8388608;
    return x[31:24];
  endfunction

  function automatic logic [7:0] scale_a(input logic [12:0] a);
    logic [20:0] y;
    y = ({8'd0, a} << 8) - {8'd0, a} + 21'd2048;
    return y[19:12];
  endfunction

  logic [8:5] v_q;
  logic [8:5] en;
  logic [8:5] span_q;

  logic [31:0] f5_q;
  logic [12:0] c6_q [4];
  logic [12:0] lo_c [4];
  logic [12:0] hi_c [4];
  logic [25:0] ca7_q [3];
  logic [12:0] a7_q;
  logic [31:0] pix8_q;

  assign en[8] = !v_q[8] || !out_stall_i;
  assign en[7] = !v_q[7] || en[8];
  assign en[6] = !v_q[6] || en[7];
  assign en[5] = !v_q[5] || en[6];
  assign en_o  = en[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[5]) v_q[5] <= seg_i.valid;
      if (en[6]) v_q[6] <= v_q[5];
      if (en[7]) v_q[7] <= v_q[6];
      if (en[8]) v_q[8] <= v_q[7];
    end
  end

  always_comb begin
    lo_c[0] = stop_lo_i.r;
    lo_c[1] = stop_lo_i.g;
    lo_c[2] = stop_lo_i.b;
    lo_c[3] = stop_lo_i.a;
    hi_c[0] = stop_hi_i.r;
    hi_c[1] = stop_hi_i.g;
    hi_c[2] = stop_hi_i.b;
    hi_c[3] = stop_hi_i.a;
  end

  // The stop colours for stage 5 sit in the table's read registers.
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f5_q      <= seg_i.frac;
      span_q[5] <= seg_i.span_end;
    end
    if (en[6]) begin
      span_q[6] <= span_q[5];
      for (int k = 0; k < 4; k++) begin
        c6_q[k] <= blend(lo_c[k], hi_c[k], f5_q);
      end
    end
    if (en[7]) begin
      span_q[7] <= span_q[6];
      a7_q      <= c6_q[3];
      for (int k = 0; k < 3; k++) begin
        ca7_q[k] <= c6_q[k] * c6_q[3];
      end
    end
    if (en[8]) begin
      span_q[8] <= span_q[7];
      pix8_q    <= {scale_a(a7_q), scale_c(ca7_q[0]), scale_c(ca7_q[1]),
                    scale_c(ca7_q[2])};
    end
  end

  assign out_valid_o = v_q[8];
  assign pixel_out_o = pix8_q;
  assign span_end_o  = span_q[8];

endmodule

/* hw/rtl/linear_gradient_shader.sv */
// Linear gradient shader: eight-stage pixel pipeline with a stop table and register port.
//
// The input channel carries commands. A load command writes one colour stop,
// pinning each channel to [0,1], and gives no result. A shade command gives one
// premultiplied ARGB pixel together with a copy of its row_end flag.
// Both channels use valid and stall; a transaction completes on a clock edge with
// valid high and stall low. A shade transaction passes all eight register stages
// before it reaches out_valid_o. One transaction is accepted every cycle while
// in_stall_o is low: products, the three-term sum, tiling, segment multiply, stop
// table read, blend, premultiply and packing each take one register stage.
// While the receiver stalls, the output register holds its pixel and earlier
// stages keep filling empty slots; in_stall_o rises only once all eight stages
// hold transactions. Stops load in order with the pixels around them. Reset clears
// the pipeline and the registers (zero coefficients, clamp, one stop). The stop
// table is not cleared: every stop must be loaded before a pixel that uses it is
// shaded. Registers must be written by the user only while idle, at byte address
// 8*i through the 64-bit register port; the block itself has no check for this.
module linear_gradient_shader import lgs_pkg::*; #(
  parameter int MAX_STOPS = LGS_MAX_STOPS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [LGS_APB_AW-1:0]  paddr,
  input  logic [LGS_APB_DW-1:0]  pwdata,
  output logic [LGS_APB_DW-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [0:0]             command_i,
  input  logic [11:0]            pixel_x_i,
  input  logic [11:0]            pixel_y_i,
  input  logic                   row_end_i,
  input  logic [3:0]             stop_index_i,
  input  logic signed [15:0]     red_in_i,
  input  logic signed [15:0]     green_in_i,
  input  logic signed [15:0]     blue_in_i,
  input  logic signed [15:0]     alpha_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            pixel_out_o,
  output logic                   span_end_o
);

  localparam int IdxW = lgs_idx_w(MAX_STOPS);

  logic signed [39:0] coeff_x_q, coeff_y_q, coeff_offset_q;
  tile_e              tile_mode_q;
  logic [4:0]         stop_count_q;
  logic [2:0]         reg_idx;
  logic               wr;
  cfg_t               cfg;

  seg_t            seg;
  logic            en5;
  logic [IdxW-1:0] rd_lo, rd_hi, wr_idx;
  logic            wr_en;
  stop_t           wr_stop, stop_lo, stop_hi;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_x_q      <= '0;
      coeff_y_q      <= '0;
      coeff_offset_q <= '0;
      tile_mode_q    <= TILE_CLAMP;
      stop_count_q   <= 5'd1;
    end else if (wr) begin
      unique case (reg_idx)
        LGS_REG_COEFF_X:      coeff_x_q      <= pwdata[39:0];
        LGS_REG_COEFF_Y:      coeff_y_q      <= pwdata[39:0];
        LGS_REG_COEFF_OFFSET: coeff_offset_q <= pwdata[39:0];
        LGS_REG_TILE_MODE:    tile_mode_q    <= tile_e'(pwdata[1:0]);
        LGS_REG_STOP_COUNT:   stop_count_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      LGS_REG_COEFF_X:      prdata = {24'd0, coeff_x_q};
      LGS_REG_COEFF_Y:      prdata = {24'd0, coeff_y_q};
      LGS_REG_COEFF_OFFSET: prdata = {24'd0, coeff_offset_q};
      LGS_REG_TILE_MODE:    prdata = {62'd0, tile_mode_q};
      LGS_REG_STOP_COUNT:   prdata = {59'd0, stop_count_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg.coeff_x      = coeff_x_q;
  assign cfg.coeff_y      = coeff_y_q;
  assign cfg.coeff_offset = coeff_offset_q;
  assign cfg.tile_mode    = tile_mode_q;
  assign cfg.stop_count   = stop_count_q;

  lgs_param_pipe #(
    .MAX_STOPS (MAX_STOPS)
  ) u_param (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .valid_i      (in_valid_i),
    .stall_o      (in_stall_o),
    .command_i    (command_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .row_end_i    (row_end_i),
    .stop_index_i (stop_index_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .dn_en_i      (en5),
    .seg_o        (seg),
    .rd_lo_o      (rd_lo),
    .rd_hi_o      (rd_hi),
    .wr_en_o      (wr_en),
    .wr_idx_o     (wr_idx),
    .wr_stop_o    (wr_stop)
  );

  lgs_stop_ram #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx),
    .wr_data_i   (wr_stop),
    .rd_en_i     (en5),
    .rd_lo_idx_i (rd_lo),
    .rd_hi_idx_i (rd_hi),
    .rd_lo_o     (stop_lo),
    .rd_hi_o     (stop_hi)
  );

  lgs_color_pipe u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg),
    .en_o        (en5),
    .stop_lo_i   (stop_lo),
    .stop_hi_i   (stop_hi),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .span_end_o  (span_end_o)
  );

endmodule

/* hw/rtl/lgs_checker.sv */
// Port-level checker of the linear gradient shader and its bind statement.
`include "linear_gradient_shader_defines.svh"

module lgs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [31:0] pixel_out_i,
  input logic        span_end_i
);

  // A held output transaction keeps its payload.
  `LGS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
    out_valid_i && $stable(pixel_out_i) && $stable(span_end_i), "output changed under stall")

  // Back-pressure on the input can only come from a stalled, full output stage.
  `LGS_ASSERT_IMPL(a_stall_src, clk_i, rst_ni, in_stall_i,
    out_valid_i && out_stall_i, "input stalled while output is free")

  // Premultiplied colour bytes never exceed the alpha byte.
  `LGS_ASSERT_IMPL(a_premul, clk_i, rst_ni, out_valid_i,
    (pixel_out_i[23:16] <= pixel_out_i[31:24]) && (pixel_out_i[15:8] <= pixel_out_i[31:24])
    && (pixel_out_i[7:0] <= pixel_out_i[31:24]), "colour byte above alpha")

endmodule

bind linear_gradient_shader lgs_checker u_lgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_i (pixel_out_o),
  .span_end_i  (span_end_o)
);

/* bench/tb_linear_gradient_shader.sv */
// Self-checking testbench for the linear gradient shader: stop loads, tiling modes and blending.
module tb_linear_gradient_shader;
  import lgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 8;
  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;
  localparam longint unsigned Q32_MASK = Q32_ONE - 1;
  localparam logic [1:0] TILE_UNUSED = 2'd3;
  localparam logic [63:0] COEFF_MAX = 64'h0000_007F_FFFF_FFFF;
  localparam logic [63:0] COEFF_MIN = 64'hFFFF_FF80_0000_0000;

  typedef struct {
    logic [31:0] pixel;
    logic        span_end;
  } shaded_px_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [LGS_APB_AW-1:0] paddr = '0;
  logic [LGS_APB_DW-1:0] pwdata = '0;
  logic [LGS_APB_DW-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [0:0]            command_i = CMD_LOAD;
  logic [11:0]           pixel_x_i = '0;
  logic [11:0]           pixel_y_i = '0;
  logic                  row_end_i = 1'b0;
  logic [3:0]            stop_index_i = '0;
  logic signed [15:0]    red_in_i = '0;
  logic signed [15:0]    green_in_i = '0;
  logic signed [15:0]    blue_in_i = '0;
  logic signed [15:0]    alpha_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [31:0]           pixel_out_o;
  logic                  span_end_o;

  // Shadow of the block's registers and stop table.
  longint     coeff_x_q = 0;
  longint     coeff_y_q = 0;
  longint     coeff_off_q = 0;
  logic [1:0] tile_q = TILE_CLAMP;
  logic [4:0] count_q = 5'd1;
  stop_t      stop_table_q [LGS_MAX_STOPS];

  shaded_px_t expected_pixels [$];
  int         mismatches = 0;
  bit         bursts_on = 1'b1;
  int         stall_run = 0;

  linear_gradient_shader i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .row_end_i   (row_end_i),
    .stop_index_i(stop_index_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .span_end_o  (span_end_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [12:0] pin_q12(input logic signed [15:0] v);
    if (v < 0) return 13'd0;
    if (v > 16'sd4096) return 13'd4096;
    return v[12:0];
  endfunction

  function automatic logic [31:0] pack_argb(input stop_t c);
    longint unsigned a, ab, rb, gb, bb;
    a  = longint'(c.a);
    ab = (a * 255 + 2048) >> 12;
    rb = (longint'(c.r) * a * 255 + 64'h80_0000) >> 24;
    gb = (longint'(c.g) * a * 255 + 64'h80_0000) >> 24;
    bb = (longint'(c.b) * a * 255 + 64'h80_0000) >> 24;
    return {ab[7:0], rb[7:0], gb[7:0], bb[7:0]};
  endfunction

  function automatic logic [12:0] blend_q12(input logic [12:0] lo, input logic [12:0] hi,
                                            input longint unsigned f);
    longint unsigned acc;
    acc = longint'(lo) * (Q32_ONE - f) + longint'(hi) * f + 64'h8000_0000;
    return 13'(acc >> 32);
  endfunction

  function automatic logic [31:0] shade_pixel(input logic [11:0] px, input logic [11:0] py);
    longint          ts;
    longint unsigned t, prod, f;
    int              cnt, seg;
    stop_t           c;
    ts  = coeff_x_q * longint'(px) + coeff_y_q * longint'(py) + coeff_off_q;
    cnt = int'(count_q);
    if (cnt < 1) cnt = 1;
    if (cnt > LGS_MAX_STOPS) cnt = LGS_MAX_STOPS;
    case (tile_q)
      TILE_REPEAT: t = ts & Q32_MASK;
      TILE_MIRROR: begin
        // Fold the period-two ramp back down in its second half.
        t = ts & ((Q32_ONE << 1) - 1);
        if (t > Q32_ONE) t = (Q32_ONE << 1) - t;
      end
      default: begin
        if (ts < 0) t = 0;
        else if (ts > longint'(Q32_ONE)) t = Q32_ONE;
        else t = ts;
      end
    endcase
    if (t == 0 || cnt == 1) return pack_argb(stop_table_q[0]);
    if (t >= Q32_ONE) return pack_argb(stop_table_q[cnt - 1]);
    prod = t * longint'(cnt - 1);
    seg  = int'(prod >> 32);
    f    = prod & Q32_MASK;
    if (seg >= cnt - 1) seg = cnt - 2;
    c.r = blend_q12(stop_table_q[seg].r, stop_table_q[seg + 1].r, f);
    c.g = blend_q12(stop_table_q[seg].g, stop_table_q[seg + 1].g, f);
    c.b = blend_q12(stop_table_q[seg].b, stop_table_q[seg + 1].b, f);
    c.a = blend_q12(stop_table_q[seg].a, stop_table_q[seg + 1].a, f);
    return pack_argb(c);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_output
    shaded_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %08h with no shade transaction pending", pixel_out_o));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out_o !== want.pixel)
          report_mismatch($sformatf("pixel_out %08h, expected %08h", pixel_out_o, want.pixel));
        if (span_end_o !== want.span_end)
          report_mismatch($sformatf("span_end %0b, expected %0b", span_end_o, want.span_end));
      end
    end
  end

  // Receiver stalls in random bursts.
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (bursts_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic set_reg(input logic [2:0] reg_sel, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_sel)
      LGS_REG_COEFF_X:      coeff_x_q = longint'(signed'(value[39:0]));
      LGS_REG_COEFF_Y:      coeff_y_q = longint'(signed'(value[39:0]));
      LGS_REG_COEFF_OFFSET: coeff_off_q = longint'(signed'(value[39:0]));
      LGS_REG_TILE_MODE:    tile_q = value[1:0];
      LGS_REG_STOP_COUNT:   count_q = value[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_item(input cmd_e cmd, input logic [11:0] x, input logic [11:0] y,
                           input logic last, input logic [3:0] idx,
                           input logic signed [15:0] r, input logic signed [15:0] g,
                           input logic signed [15:0] b, input logic signed [15:0] a);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    pixel_x_i    <= x;
    pixel_y_i    <= y;
    row_end_i    <= last;
    stop_index_i <= idx;
    red_in_i     <= r;
    green_in_i   <= g;
    blue_in_i    <= b;
    alpha_in_i   <= a;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_SHADE)
      expected_pixels.push_back('{pixel: shade_pixel(x, y), span_end: last});
    else
      stop_table_q[idx] = '{r: pin_q12(r), g: pin_q12(g), b: pin_q12(b), a: pin_q12(a)};
    @(negedge clk_i);
  endtask

  task automatic shade_at(input logic [11:0] x, input logic [11:0] y, input logic last);
    send_item(CMD_SHADE, x, y, last, 4'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic load_stop(input logic [3:0] idx, input logic signed [15:0] r,
                           input logic signed [15:0] g, input logic signed [15:0] b,
                           input logic signed [15:0] a);
    send_item(CMD_LOAD, 12'($urandom), 12'($urandom), 1'($urandom), idx, r, g, b, a);
  endtask

  // Holds the input channel until every shade transaction has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  // A load in flight gives no result, so let the pipeline empty before a register write.
  task automatic settle();
    drain();
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_channel();
    if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 4096));
    return 16'($urandom);
  endfunction

  // Signed value in [-2^sh, 2^sh) for a shift drawn from the given range.
  function automatic longint rand_coeff(input int unsigned lo_sh, input int unsigned hi_sh);
    longint v;
    v = {$urandom, $urandom};
    return v >>> (63 - $urandom_range(lo_sh, hi_sh));
  endfunction

  // ---------------------------------------------------------------- tests

  // Every stop is written before any shade can read it; pinning is covered on both sides.
  task automatic test_stop_table_load();
    load_stop(4'd0, -16'sd32768, 16'sd32767, 16'sd4096, 16'sd4096);
    load_stop(4'd1, 16'sd4097, -16'sd1, 16'sd0, 16'sd0);
    for (int i = 2; i < LGS_MAX_STOPS - 1; i++)
      load_stop(4'(i), 16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                16'($urandom_range(0, 4096)), 16'($urandom_range(1, 4096)));
    load_stop(4'd15, 16'sd2048, 16'sd1024, 16'sd4095, 16'sd3000);
  endtask

  task automatic test_end_stops();
    // Reset state: one stop, so every pixel takes the first stop.
    shade_at(12'd0, 12'd0, 1'b0);
    shade_at(12'hFFF, 12'hFFF, 1'b1);
    settle();
    set_reg(LGS_REG_STOP_COUNT, 64'd16);
    set_reg(LGS_REG_COEFF_OFFSET, Q32_ONE);
    shade_at(12'd7, 12'd9, 1'b1);
    settle();
    set_reg(LGS_REG_COEFF_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
    shade_at(12'd1, 12'd2, 1'b0);
    settle();
    set_reg(LGS_REG_COEFF_OFFSET, 64'h8000_0000);
    shade_at(12'd0, 12'd0, 1'b1);
    settle();
  endtask

  task automatic test_tile_modes();
    set_reg(LGS_REG_COEFF_X, 64'd4294967);
    set_reg(LGS_REG_COEFF_Y, -64'sd3145728);
    set_reg(LGS_REG_COEFF_OFFSET, 64'd0);
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_REPEAT));
    shade_at(12'hFFF, 12'd0, 1'b0);
    shade_at(12'd1000, 12'd2000, 1'b1);
    settle();
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_MIRROR));
    shade_at(12'hFFF, 12'd0, 1'b0);
    shade_at(12'd1000, 12'd2000, 1'b1);
    settle();
    // The unused tile code falls back to clamping.
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_UNUSED));
    shade_at(12'd1000, 12'd2000, 1'b1);
    settle();
  endtask

  task automatic test_count_limits();
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_CLAMP));
    set_reg(LGS_REG_COEFF_Y, 64'd0);
    set_reg(LGS_REG_STOP_COUNT, 64'd0);
    shade_at(12'd500, 12'd0, 1'b1);
    settle();
    set_reg(LGS_REG_STOP_COUNT, 64'd17);
    shade_at(12'd500, 12'd0, 1'b0);
    settle();
    set_reg(LGS_REG_STOP_COUNT, 64'd31);
    shade_at(12'd500, 12'd0, 1'b1);
    settle();
  endtask

  task automatic test_coeff_extremes();
    set_reg(LGS_REG_STOP_COUNT, 64'd16);
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_REPEAT));
    set_reg(LGS_REG_COEFF_X, COEFF_MAX);
    set_reg(LGS_REG_COEFF_Y, COEFF_MIN);
    set_reg(LGS_REG_COEFF_OFFSET, COEFF_MAX);
    shade_at(12'hFFF, 12'd0, 1'b0);
    shade_at(12'd0, 12'hFFF, 1'b0);
    shade_at(12'hFFF, 12'hFFF, 1'b1);
    settle();
    set_reg(LGS_REG_TILE_MODE, 64'(TILE_MIRROR));
    set_reg(LGS_REG_COEFF_X, COEFF_MIN);
    set_reg(LGS_REG_COEFF_OFFSET, COEFF_MIN);
    shade_at(12'hFFF, 12'h123, 1'b1);
    settle();
  endtask

  // Spans of consecutive pixels with stop reloads mixed in, under a new setting per phase.
  task automatic test_random_spans(input int phases, input int per_phase);
    int          sent;
    int          span_len;
    bit          drained_once;
    logic [11:0] x, y;
    logic [1:0]  tile_sel;
    logic [4:0]  count_sel;
    drained_once = 1'b0;
    for (int p = 0; p < phases; p++) begin
      settle();
      bursts_on = (p != phases - 1);
      tile_sel  = ($urandom_range(0, 9) == 0) ? TILE_UNUSED : 2'($urandom_range(0, 2));
      count_sel = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
      set_reg(LGS_REG_COEFF_X, ($urandom_range(0, 3) != 0) ? rand_coeff(16, 24)
                                                           : rand_coeff(14, 39));
      set_reg(LGS_REG_COEFF_Y, ($urandom_range(0, 3) != 0) ? rand_coeff(16, 24)
                                                           : rand_coeff(14, 39));
      set_reg(LGS_REG_COEFF_OFFSET, ($urandom_range(0, 3) != 0) ? rand_coeff(28, 34)
                                                                : rand_coeff(14, 39));
      set_reg(LGS_REG_TILE_MODE, 64'(tile_sel));
      set_reg(LGS_REG_STOP_COUNT, 64'(count_sel));
      sent = 0;
      while (sent < per_phase) begin
        if (p == phases / 2 && sent >= per_phase / 2 && !drained_once) begin
          drain();
          drained_once = 1'b1;
        end
        if ($urandom_range(0, 99) < 15) begin
          load_stop(4'($urandom), rand_channel(), rand_channel(), rand_channel(),
                    rand_channel());
          sent++;
        end else begin
          span_len = $urandom_range(1, 16);
          x = 12'($urandom);
          y = 12'($urandom);
          for (int k = 0; k < span_len; k++)
            shade_at(x + 12'(k), y, k == span_len - 1);
          sent += span_len;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_stop_table_load();
    test_end_stops();
    test_tile_modes();
    test_count_limits();
    test_coeff_extremes();
    test_random_spans(10, 145);
    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
